// ----- src/rrla_pkg.sv -----
// Types and constants shared by the receive ring line assembler.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rrla_pkg;

   localparam int LEN_W = 6;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [2:0] {
      STS_STORED     = 3'd0,
      STS_RING_FULL  = 3'd1,
      STS_RING_EMPTY = 3'd2,
      STS_APPENDED   = 3'd3,
      STS_EMPTY_TERM = 3'd4,
      STS_TOO_LONG   = 3'd5,
      STS_LINE_CHAR  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       line_char;
      logic             last;
      logic [LEN_W-1:0] line_length;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_sts_type;

   typedef struct packed {
      logic append;
      logic clear;
      logic read;
   } line_ctl_type;

endpackage

`default_nettype wire

// ----- src/receive_ring_line_assembler_top.sv -----
// Top level of the receive ring line assembler: sequencer and result register.
// Depends on rrla_pkg, rrla_ring and rrla_line.
`timescale 1ns / 1ps
`default_nettype none

// Receive side of a serial console.
// req channel: one beat per item. mode 0 pushes rx_byte into the ring (dropped
// with a ring-full status when the ring already holds RING_DEPTH-1 bytes);
// mode 1 pops one byte and feeds it to the line assembler.
// rsp channel: one beat per result. A popped CR or LF that closes a non-empty
// line yields one line-char beat per stored character, last set on the final
// one; every other item yields exactly one beat with last set.
// Timing: a push or a pop of an empty ring loads its beat straight into the result
// register. A pop with data first goes through the ring memory's registered read. A line
// of n characters then streams at one beat per cycle while rsp_stall is low, set by the
// single read port of the line memory.
// One item is in work at a time: req_stall is high until the item's last beat
// sits in the result register and that register can take another beat.
// rsp_stall holds the result register and everything behind it; no beat is
// lost or repeated. Reset clears pointers, fill count, sequencer and rsp_valid;
// the memories need no clearing, since only written entries are ever read.
module receive_ring_line_assembler_top
   import rrla_pkg::*;
#(
   parameter int RING_DEPTH = 256,
   parameter int LINE_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int FW = $clog2(LINE_DEPTH);
   localparam logic [FW-1:0] FILL_MAX = FW'(LINE_DEPTH - 1);

   state_type     state_ff, state_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   ring_ctl_type  ring_ctl;
   ring_sts_type  ring_sts;
   logic [7:0]    ring_rd_data;
   line_ctl_type  line_ctl;
   logic [7:0]    line_rd_data;
   logic [FW-1:0] fill;

   logic          rsp_free;
   logic          rsp_load;
   rsp_type       rsp_next;
   logic          accept;
   logic          is_term;
   logic          emit_last;

   rrla_ring #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ring_ctl),
      .wr_data(req_data.rx_byte),
      .rd_data(ring_rd_data),
      .sts    (ring_sts)
   );

   rrla_line #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_line (
      .clock  (clock),
      .reset  (reset),
      .ctl    (line_ctl),
      .wr_data(ring_rd_data),
      .rd_addr(idx_in),
      .rd_data(line_rd_data),
      .fill   (fill)
   );

   // The result register can take a beat when empty or when its beat leaves now.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_term   = (ring_rd_data == CHAR_CR) || (ring_rd_data == CHAR_LF);
   assign emit_last = (idx_ff == fill - FW'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.mode && !ring_sts.empty) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (is_term && fill != '0) begin
               state_in = ST_EMIT;
            end else if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and memory controls
   always_comb begin
      req_stall = 1'b1;
      ring_ctl  = '0;
      line_ctl  = '0;
      rsp_load  = 1'b0;
      rsp_next  = '{status: STS_STORED, line_char: 8'd0, last: 1'b1,
                    line_length: LEN_W'(fill)};
      idx_in    = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !rsp_free;
            if (accept) begin
               if (!req_data.mode) begin
                  // push, or drop when full
                  ring_ctl.push = !ring_sts.full;
                  rsp_load      = 1'b1;
                  rsp_next.status = ring_sts.full ? STS_RING_FULL : STS_STORED;
               end else if (ring_sts.empty) begin
                  rsp_load        = 1'b1;
                  rsp_next.status = STS_RING_EMPTY;
               end else begin
                  ring_ctl.pop = 1'b1;
               end
            end
         end
         ST_READ: begin
            if (is_term && fill != '0) begin
               // start streaming the line from its first character
               line_ctl.read = 1'b1;
               idx_in        = '0;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               if (is_term) begin
                  rsp_next.status      = STS_EMPTY_TERM;
                  rsp_next.line_length = '0;
               end else if (fill != FILL_MAX) begin
                  line_ctl.append      = 1'b1;
                  rsp_next.status      = STS_APPENDED;
                  rsp_next.line_length = LEN_W'(fill + FW'(1));
               end else begin
                  // overlong: drop the line and the byte
                  line_ctl.clear       = 1'b1;
                  rsp_next.status      = STS_TOO_LONG;
                  rsp_next.line_length = '0;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load           = 1'b1;
               rsp_next.status    = STS_LINE_CHAR;
               rsp_next.line_char = line_rd_data;
               rsp_next.last      = emit_last;
               if (emit_last) begin
                  line_ctl.clear = 1'b1;
               end else begin
                  line_ctl.read = 1'b1;
                  idx_in        = idx_ff + FW'(1);
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("item accepted while a previous item is in work");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("held result beat overwritten");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff < fill))
      else $error("line index beyond fill count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.push |-> !ring_sts.full)
      else $error("push into a full ring");

   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && state_in == ST_EMIT) |=> (idx_ff == '0))
      else $error("line streaming did not start at the first character");

endmodule

`default_nettype wire

// ----- src/rrla_ring.sv -----
// Receive ring: byte memory with registered read and its pointers.
// Depends on rrla_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rrla_ring
   import rrla_pkg::*;
#(
   parameter int RING_DEPTH = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ring_ctl_type ctl,
   input  wire logic [7:0]   wr_data,
   output      logic [7:0]   rd_data,
   output      ring_sts_type sts
);

   localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [RW-1:0] PTR_LAST = RW'(RING_DEPTH - 1);

   logic [7:0]    mem [RING_DEPTH];
   logic [RW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RW-1:0] wr_next;
   logic [RW-1:0] rd_next;
   logic [7:0]    rd_data_ff;

   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + RW'(1);
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + RW'(1);

   // One slot stays unused so that full and empty differ.
   assign sts.full  = (wr_next == rd_ptr_ff);
   assign sts.empty = (wr_ptr_ff == rd_ptr_ff);

   assign wr_ptr_in = ctl.push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = ctl.pop  ? rd_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/rrla_line.sv -----
// Line store: character memory with registered read and fill count.
// Depends on rrla_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module rrla_line
   import rrla_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire line_ctl_type                  ctl,
   input  wire logic [7:0]                    wr_data,
   input  wire logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
   output      logic [7:0]                    rd_data,
   output      logic [$clog2(LINE_DEPTH)-1:0] fill
);

   localparam int FW = $clog2(LINE_DEPTH);

   logic [7:0]    mem [LINE_DEPTH];
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    rd_data_ff;

   always_comb begin
      fill_in = fill_ff;
      if (ctl.clear) begin
         fill_in = '0;
      end else if (ctl.append) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.append) begin
         mem[fill_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

`default_nettype wire

// ----- tb/sv/receive_ring_line_assembler_top_tb.sv -----
// Self-checking testbench for receive_ring_line_assembler_top.
// Depends on rrla_pkg and the block's RTL; a directed table and random line traffic are
// scored against a behavioral line assembler kept inside this file.
`timescale 1ns / 1ps

module receive_ring_line_assembler_top_tb;
   import rrla_pkg::*;

   localparam int RING_DEPTH      = 256;
   localparam int LINE_DEPTH      = 64;
   localparam int CLOCK_HALF_NS   = 6;
   localparam int RESET_CYCLES    = 12;
   localparam int MAX_WAIT        = 19;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 6;
   localparam int TAIL_CYCLES     = LINE_DEPTH + 8;
   localparam int RANDOM_ITEMS    = 20;
   localparam int LIMIT_CYCLES    = 1500000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   receive_ring_line_assembler_top #(
      .RING_DEPTH(RING_DEPTH),
      .LINE_DEPTH(LINE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Line assembler shadow: ring of received bytes and the partial line.
   // ---------------------------------------------------------------------------------------
   logic [7:0]  shadow_ring [RING_DEPTH];
   int unsigned ring_wr = 0;
   int unsigned ring_rd = 0;
   logic [7:0]  shadow_line [LINE_DEPTH];
   int unsigned line_fill = 0;

   rsp_type     expected_beats [$];
   int unsigned mismatch_count = 0;

   // scoreboard-side state shared by the sender and the receiver
   int unsigned items_sent      = 0;
   int unsigned ring_backlog    = 0;   // generator's view of bytes waiting in the ring
   bit          sender_eager    = 1'b0;
   bit          hold_off_request = 1'b0;
   int unsigned cycle_count     = 0;

   function automatic void note_beat(input status_type st, input logic [7:0] ch,
                                     input logic lst, input int unsigned len);
      rsp_type beat;
      beat             = '0;
      beat.status      = st;
      beat.line_char   = ch;
      beat.last        = lst;
      beat.line_length = len[LEN_W-1:0];
      expected_beats.push_back(beat);
   endfunction

   // Work out every beat one accepted item causes and advance the shadow state.
   function automatic void assemble_item(input req_type item);
      logic [7:0]  c;
      int unsigned nxt;
      int unsigned n;
      int unsigned i;
      if (item.mode == MODE_PUSH) begin
         nxt = (ring_wr + 1) % RING_DEPTH;
         if (nxt != ring_rd) begin
            shadow_ring[ring_wr] = item.rx_byte;
            ring_wr = nxt;
            note_beat(STS_STORED, 8'h00, 1'b1, line_fill);
         end else begin
            // ring holds RING_DEPTH-1 bytes: drop the byte, keep the pointers
            note_beat(STS_RING_FULL, 8'h00, 1'b1, line_fill);
         end
      end else if (ring_rd == ring_wr) begin
         note_beat(STS_RING_EMPTY, 8'h00, 1'b1, line_fill);
      end else begin
         c = shadow_ring[ring_rd];
         ring_rd = (ring_rd + 1) % RING_DEPTH;
         if (c == CHAR_CR || c == CHAR_LF) begin
            if (line_fill == 0) begin
               note_beat(STS_EMPTY_TERM, 8'h00, 1'b1, 0);
            end else begin
               n = line_fill;
               for (i = 0; i < n; i++)
                  note_beat(STS_LINE_CHAR, shadow_line[i], (i + 1 == n), n);
               line_fill = 0;
            end
         end else if (line_fill < LINE_DEPTH - 1) begin
            shadow_line[line_fill] = c;
            line_fill++;
            note_beat(STS_APPENDED, 8'h00, 1'b1, line_fill);
         end else begin
            // overlong line: discard it together with this byte
            line_fill = 0;
            note_beat(STS_TOO_LONG, 8'h00, 1'b1, 0);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------------
   function automatic int unsigned pick_wait(input bit eager);
      return eager ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Offer one beat, hold it until accepted, then predict it. Acceptance is decided at the
   // falling edge, where req_stall is settled, and takes effect at the next rising edge.
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int unsigned gap;
      bit          accepted;
      gap = pick_wait(sender_eager);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = (req_stall === 1'b0);
         @(posedge clock);
      end
      assemble_item(item);
      // rows with a typed result cause exactly one beat: replace the predicted one
      if (typed)
         expected_beats[expected_beats.size() - 1] = want;
      items_sent++;
      if (item.mode == MODE_PUSH) begin
         if (ring_backlog < RING_DEPTH - 1) ring_backlog++;
      end else if (ring_backlog > 0) begin
         ring_backlog--;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      req_type item;
      item.mode    = MODE_PUSH;
      item.rx_byte = b;
      send_item(item, 1'b0, '0);
   endtask

   task automatic pop_byte();
      req_type item;
      item.mode    = MODE_POP;
      item.rx_byte = 8'($urandom_range(0, 255));   // ignored by the block, vary it anyway
      send_item(item, 1'b0, '0);
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   function automatic logic [7:0] pick_terminator();
      return ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF;
   endfunction

   // Push a line of text bytes, draining the ring now and then, optionally close it, and
   // drain what is left so the line gets assembled.
   task automatic random_line(input int unsigned n_chars, input bit closed);
      int unsigned k;
      for (k = 0; k < n_chars; k++) begin
         push_byte(text_byte());
         if ($urandom_range(0, 2) == 0 && ring_backlog != 0) pop_byte();
      end
      if (closed) push_byte(pick_terminator());
      while (ring_backlog != 0) pop_byte();
   endtask

   // Drop valid and hold until every predicted beat has come back.
   task automatic wait_idle(input int unsigned settle);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver side: draw a stall before each beat, then take and score it.
   // ---------------------------------------------------------------------------------------
   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (expected_beats.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Unexpected beat: status %0d char %02h last %0d len %0d",
                     got.status, got.line_char, got.last, got.line_length);
      end else begin
         want = expected_beats.pop_front();
         if (got.status !== want.status || got.line_char !== want.line_char ||
             got.last !== want.last || got.line_length !== want.line_length) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"Mismatch: expected status %0d char %02h last %0d len %0d, ",
                         "got %0d %02h %0d %0d"},
                        want.status, want.line_char, want.last, want.line_length,
                        got.status, got.line_char, got.last, got.line_length);
         end
      end
   endtask

   initial begin : receiver
      int unsigned stall_cycles;
      bit          sink_eager;
      bit          got_beat;
      rsp_type     beat;
      sink_eager = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // switch between stretches of free flow and random stalls
         if ($urandom_range(0, 29) == 0) sink_eager = !sink_eager;
         stall_cycles = pick_wait(sink_eager);
         if (hold_off_request) begin
            // long hold-off: the block backs up and stalls the sender
            hold_off_request = 1'b0;
            stall_cycles = HOLD_OFF_CYCLES;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         got_beat = 1'b0;
         while (!got_beat) begin
            @(negedge clock);
            got_beat = (rsp_valid === 1'b1);
            beat = rsp_data;
            @(posedge clock);
         end
         check_beat(beat);
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------------------------
   stim_row_type directed_rows [$];

   task automatic add_row(input logic mode, input logic [7:0] b, input bit typed,
                          input status_type st, input int unsigned len);
      stim_row_type row;
      row.item.mode    = mode;
      row.item.rx_byte = b;
      row.typed        = typed;
      row.want             = '0;
      row.want.status      = st;
      row.want.last        = 1'b1;
      row.want.line_length = len[LEN_W-1:0];
      directed_rows.push_back(row);
   endtask

   task automatic build_directed();
      add_row(MODE_POP,  8'h00,   1'b1, STS_RING_EMPTY, 0);   // consume right after reset
      add_row(MODE_PUSH, CHAR_LF, 1'b1, STS_STORED,     0);
      add_row(MODE_POP,  8'h00,   1'b1, STS_EMPTY_TERM, 0);   // LF on an empty line
      add_row(MODE_PUSH, CHAR_CR, 1'b1, STS_STORED,     0);
      add_row(MODE_POP,  8'hFF,   1'b1, STS_EMPTY_TERM, 0);   // CR on an empty line
      add_row(MODE_PUSH, 8'h00,   1'b1, STS_STORED,     0);
      add_row(MODE_PUSH, 8'hFF,   1'b1, STS_STORED,     0);
      add_row(MODE_PUSH, 8'h41,   1'b1, STS_STORED,     0);
      add_row(MODE_PUSH, CHAR_CR, 1'b1, STS_STORED,     0);
      add_row(MODE_POP,  8'h00,   1'b1, STS_APPENDED,   1);
      add_row(MODE_POP,  8'h00,   1'b1, STS_APPENDED,   2);
      add_row(MODE_POP,  8'h00,   1'b1, STS_APPENDED,   3);
      add_row(MODE_POP,  8'h00,   1'b0, STS_LINE_CHAR,  3);   // CR closes a three-char line
      add_row(MODE_POP,  8'h00,   1'b1, STS_RING_EMPTY, 0);
      add_row(MODE_PUSH, 8'h7F,   1'b1, STS_STORED,     0);
      add_row(MODE_PUSH, 8'h80,   1'b1, STS_STORED,     0);
      add_row(MODE_PUSH, CHAR_LF, 1'b1, STS_STORED,     0);
      add_row(MODE_POP,  8'h00,   1'b1, STS_APPENDED,   1);
      add_row(MODE_POP,  8'h00,   1'b1, STS_APPENDED,   2);
      add_row(MODE_POP,  8'h00,   1'b0, STS_LINE_CHAR,  2);   // LF closes a two-char line
      add_row(MODE_PUSH, 8'h01,   1'b1, STS_STORED,     0);
      add_row(MODE_POP,  8'h00,   1'b1, STS_APPENDED,   1);
      add_row(MODE_POP,  8'h55,   1'b1, STS_RING_EMPTY, 1);   // length reports the open line
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned k;
      int unsigned pick;
      int unsigned random_start;
      req_type     noise;
      for (k = 0; k < RING_DEPTH; k++) shadow_ring[k] = 8'h00;
      for (k = 0; k < LINE_DEPTH; k++) shadow_line[k] = 8'h00;
      build_directed();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (k = 0; k < directed_rows.size(); k++)
         send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
      wait_idle(SETTLE_CYCLES);

      // Push a line's worth of bytes while the receiver holds off, then drain them: the
      // drain runs the open line past its limit, so it gets discarded as overlong.
      sender_eager     = 1'b1;
      hold_off_request = 1'b1;
      for (k = 0; k < LINE_DEPTH; k++) push_byte(text_byte());
      sender_eager = 1'b0;
      for (k = 0; k < LINE_DEPTH; k++) pop_byte();

      // flush the partial line
      push_byte(CHAR_LF);
      pop_byte();
      wait_idle(SETTLE_CYCLES);

      // random traffic: mostly well-formed lines, some broken lines and noise
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         sender_eager = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 11);
         if (pick <= 6) begin
            random_line($urandom_range(0, 10), 1'b1);
         end else if (pick == 7) begin
            random_line($urandom_range(10, 20), 1'b1);
         end else if (pick == 8) begin
            random_line($urandom_range(1, 6), 1'b0);   // left open, merges with the next
         end else if (pick == 9) begin
            wait_idle($urandom_range(1, SETTLE_CYCLES));
         end else begin
            noise.mode    = 1'($urandom_range(0, 1));
            noise.rx_byte = ($urandom_range(0, 3) == 0) ? pick_terminator()
                                                        : 8'($urandom_range(0, 255));
            send_item(noise, 1'b0, '0);
         end
      end
      while (ring_backlog != 0) pop_byte();

      // drain and let any stray beat surface before the verdict
      wait_idle(TAIL_CYCLES);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
